[rtl/core/elevator_call_scheduler_defines.svh]
// Assertion macros shared by the elevator call scheduler RTL.
// Every macro expects i_clk and i_rst_n in scope; no other dependencies.
`ifndef ELEVATOR_CALL_SCHEDULER_DEFINES_SVH
`define ELEVATOR_CALL_SCHEDULER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ECS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define ECS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ecs_pkg.sv]
// Shared types, constants and helper functions of the elevator call scheduler.
// No dependencies; imported by ecs_ctrl, ecs_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ecs_pkg;

    localparam int MAX_FLOORS    = 16;
    localparam int EVENT_LIMIT   = 48;
    localparam int RESET_FLOORS  = 16;
    localparam int FLOOR_W       = 5;
    localparam int FIDX_W        = $clog2(MAX_FLOORS);
    localparam int CNT_W         = $clog2(MAX_FLOORS + 1);
    localparam int EVCNT_W       = $clog2(EVENT_LIMIT + 1);
    localparam int NIB           = (MAX_FLOORS + 3) / 4;

    typedef logic signed [1:0] t_dir;
    localparam t_dir DIR_UP   = 2'sd1;
    localparam t_dir DIR_IDLE = 2'sd0;
    localparam t_dir DIR_DOWN = -2'sd1;

    typedef enum logic [1:0] {
        EV_STOP   = 2'd0,
        EV_ARRIVE = 2'd1,
        EV_REST   = 2'd2,
        EV_REJECT = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_EVAL,
        S_REST,
        S_MOVE
    } t_state;

    typedef struct packed {
        logic   load_req;
        logic   count;
        logic   emit;
        t_event kind;
        logic   last;
        logic   clear_here;
        logic   rest;
        logic   move;
    } t_dp_cmd;

    typedef struct packed {
        logic req_ok;
        logic here;
        logic none;
        t_dir h_next;
        logic cnt_last;
    } t_dp_stat;

    function automatic logic [FLOOR_W-1:0] eff_floors(input logic [FLOOR_W-1:0] v);
        logic [FLOOR_W-1:0] f;
        f = v;
        if (f < FLOOR_W'(2)) begin
            f = FLOOR_W'(2);
        end else if (f > FLOOR_W'(MAX_FLOORS)) begin
            f = FLOOR_W'(MAX_FLOORS);
        end
        return f;
    endfunction

    // Two-level adder tree: nibble counts first, then their sum.
    function automatic logic [CNT_W-1:0] pop_count(input logic [MAX_FLOORS-1:0] v);
        logic [NIB*4-1:0]   p;
        logic [2:0]         nib [NIB];
        logic [CNT_W-1:0]   s;
        p = '0;
        p[MAX_FLOORS-1:0] = v;
        for (int k = 0; k < NIB; k++) begin
            nib[k] = 3'(p[4*k]) + 3'(p[4*k+1]) + 3'(p[4*k+2]) + 3'(p[4*k+3]);
        end
        s = '0;
        for (int k = 0; k < NIB; k++) begin
            s = s + CNT_W'(nib[k]);
        end
        return s;
    endfunction

    // Heading after a pass, given the held heading and the pending counts.
    function automatic t_dir next_heading(input t_dir h_in,
                                          input logic [CNT_W-1:0] up,
                                          input logic [CNT_W-1:0] down);
        t_dir h;
        h = h_in;
        if (h == DIR_IDLE) begin
            if (down > up) begin
                h = DIR_DOWN;
            end else if (down < up) begin
                h = DIR_UP;
            end
        end
        if (up == '0 && h == DIR_UP) begin
            h = (down != '0) ? DIR_DOWN : DIR_IDLE;
        end
        if (down == '0 && h == DIR_DOWN) begin
            h = (up != '0) ? DIR_UP : DIR_IDLE;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ecs_datapath.sv]
// Datapath of the elevator call scheduler: pending calls, car position,
// heading, pass counts, event counter and result registers. Uses ecs_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "elevator_call_scheduler_defines.svh"

module ecs_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ecs_pkg::FLOOR_W-1:0] i_cfg_wdata,
    input  wire logic [ecs_pkg::FLOOR_W-1:0] i_request_floor,
    input  wire ecs_pkg::t_dp_cmd            i_cmd,
    output ecs_pkg::t_dp_stat                o_stat,
    output logic                             o_strobe,
    output logic [1:0]                       o_event_kind,
    output logic [ecs_pkg::FLOOR_W-1:0]      o_car_floor,
    output logic signed [1:0]                o_travel_direction,
    output logic                             o_last_event
);
    import ecs_pkg::*;

    logic [MAX_FLOORS-1:0] r_pending, n_pending;
    logic [FLOOR_W-1:0]    r_pos, n_pos;
    t_dir                  r_heading, n_heading;
    logic [FLOOR_W-1:0]    r_floor_eff, n_floor_eff;
    logic [CNT_W-1:0]      r_up, r_down;
    logic                  r_here;
    logic [EVCNT_W-1:0]    r_cnt, n_cnt;

    logic                  r_strobe;
    t_event                r_kind;
    logic [FLOOR_W-1:0]    r_floor_out;
    t_dir                  r_dir_out;
    logic                  r_last;

    logic [MAX_FLOORS-1:0] above, below;
    logic [FLOOR_W-1:0]    req_m1, pos_m1, pos_next, cfg_eff;
    logic [FIDX_W-1:0]     req_idx, pos_idx;
    t_dir                  h_next;

    assign req_m1   = i_request_floor - FLOOR_W'(1);
    assign pos_m1   = r_pos - FLOOR_W'(1);
    assign req_idx  = req_m1[FIDX_W-1:0];
    assign pos_idx  = pos_m1[FIDX_W-1:0];
    assign cfg_eff  = eff_floors(i_cfg_wdata);
    assign h_next   = next_heading(r_heading, r_up, r_down);
    assign pos_next = (h_next == DIR_UP) ? r_pos + FLOOR_W'(1) : r_pos - FLOOR_W'(1);

    always_comb begin
        for (int i = 0; i < MAX_FLOORS; i++) begin
            above[i] = r_pending[i] && (i >= int'(r_pos));
            below[i] = r_pending[i] && (i < int'(r_pos) - 1);
        end
    end

    assign o_stat.req_ok   = (i_request_floor != '0) && (i_request_floor <= r_floor_eff);
    assign o_stat.here     = r_here;
    assign o_stat.none     = (r_up == '0) && (r_down == '0);
    assign o_stat.h_next   = h_next;
    assign o_stat.cnt_last = (r_cnt == EVCNT_W'(EVENT_LIMIT - 1));

    always_comb begin
        n_pending   = r_pending;
        n_pos       = r_pos;
        n_heading   = r_heading;
        n_floor_eff = r_floor_eff;
        n_cnt       = r_cnt;
        if (i_cmd.load_req) begin
            n_pending[req_idx] = 1'b1;
            n_cnt              = '0;
        end
        if (i_cmd.clear_here) begin
            n_pending[pos_idx] = 1'b0;
            n_cnt              = r_cnt + EVCNT_W'(1);
        end
        if (i_cmd.rest) begin
            n_heading = DIR_IDLE;
        end
        if (i_cmd.move) begin
            n_heading = h_next;
            n_pos     = pos_next;
            n_cnt     = r_cnt + EVCNT_W'(1);
        end
        // Shrinking the floor count drops calls above the top and pulls the car down.
        if (i_cfg_we) begin
            n_floor_eff = cfg_eff;
            for (int i = 0; i < MAX_FLOORS; i++) begin
                if (i >= int'(cfg_eff)) begin
                    n_pending[i] = 1'b0;
                end
            end
            if (r_pos > cfg_eff) begin
                n_pos = cfg_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_pos       <= FLOOR_W'(1);
            r_heading   <= DIR_IDLE;
            r_floor_eff <= eff_floors(FLOOR_W'(RESET_FLOORS));
            r_cnt       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_pos       <= n_pos;
            r_heading   <= n_heading;
            r_floor_eff <= n_floor_eff;
            r_cnt       <= n_cnt;
            r_strobe    <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.count) begin
            r_up   <= pop_count(above);
            r_down <= pop_count(below);
            r_here <= r_pending[pos_idx];
        end
        if (i_cmd.emit) begin
            r_kind <= i_cmd.kind;
            r_last <= i_cmd.last;
            case (i_cmd.kind)
                EV_ARRIVE: begin
                    r_floor_out <= pos_next;
                    r_dir_out   <= h_next;
                end
                EV_REST: begin
                    r_floor_out <= r_pos;
                    r_dir_out   <= DIR_IDLE;
                end
                default: begin
                    r_floor_out <= r_pos;
                    r_dir_out   <= r_heading;
                end
            endcase
        end
    end

    assign o_strobe           = r_strobe;
    assign o_event_kind       = r_kind;
    assign o_car_floor        = r_floor_out;
    assign o_travel_direction = r_dir_out;
    assign o_last_event       = r_last;

    `ECS_ASSERT_NOW(a_pos_in_range, 1'b1, r_pos != '0 && r_pos <= r_floor_eff, "car outside floors")
    `ECS_ASSERT_NOW(a_stop_clears, r_strobe && r_kind == EV_STOP, !r_pending[pos_idx], "stop kept call")
    `ECS_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= EVCNT_W'(EVENT_LIMIT), "event count overrun")

endmodule

`default_nettype wire

[rtl/core/ecs_ctrl.sv]
// Controller of the elevator call scheduler: sequences count, evaluate,
// stop, rest and move steps of each service pass. Uses ecs_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "elevator_call_scheduler_defines.svh"

module ecs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire ecs_pkg::t_dp_stat i_stat,
    output ecs_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);
    import ecs_pkg::*;

    t_state  r_state, n_state;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_stat.req_ok) begin
                        cmd.load_req = 1'b1;
                        n_state      = S_COUNT;
                    end else begin
                        cmd.emit = 1'b1;
                        cmd.kind = EV_REJECT;
                        cmd.last = 1'b1;
                    end
                end
            end
            S_COUNT: begin
                cmd.count = 1'b1;
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.here) begin
                    cmd.emit       = 1'b1;
                    cmd.kind       = EV_STOP;
                    cmd.clear_here = 1'b1;
                    if (i_stat.cnt_last) begin
                        cmd.last = 1'b1;
                        n_state  = S_IDLE;
                    end else if (i_stat.none) begin
                        n_state = S_REST;
                    end else if (i_stat.h_next != DIR_IDLE) begin
                        n_state = S_MOVE;
                    end else begin
                        cmd.last = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (i_stat.none) begin
                    cmd.emit = 1'b1;
                    cmd.kind = EV_REST;
                    cmd.rest = 1'b1;
                    cmd.last = 1'b1;
                    n_state  = S_IDLE;
                end else if (i_stat.h_next != DIR_IDLE) begin
                    n_state = S_MOVE;
                end else begin
                    // tie with an idle car: end the run silently
                    n_state = S_IDLE;
                end
            end
            S_REST: begin
                cmd.emit = 1'b1;
                cmd.kind = EV_REST;
                cmd.rest = 1'b1;
                cmd.last = 1'b1;
                n_state  = S_IDLE;
            end
            S_MOVE: begin
                cmd.emit = 1'b1;
                cmd.kind = EV_ARRIVE;
                cmd.move = 1'b1;
                cmd.last = i_stat.cnt_last;
                n_state  = i_stat.cnt_last ? S_IDLE : S_COUNT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

    `ECS_ASSERT_NEXT(a_last_ends_run, cmd.emit && cmd.last, r_state == S_IDLE, "run kept going")
    `ECS_ASSERT_NOW(a_move_heading, r_state == S_MOVE, i_stat.h_next != DIR_IDLE, "move w/o heading")
    `ECS_ASSERT_NOW(a_idle_quiet, r_state == S_IDLE, !cmd.count && !cmd.move, "pass step while idle")

endmodule

`default_nettype wire

[rtl/core/elevator_call_scheduler.sv]
// Top level of the elevator call scheduler: controller plus datapath.
// Depends on ecs_pkg, ecs_ctrl and ecs_datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+--------------------------------------------
//  request   | start in, busy out         | i_request_floor
//  result    | o_strobe out, no back-pres | o_event_kind, o_car_floor,
//            |                            | o_travel_direction, o_last_event
//  config    | i_cfg_we in                | i_cfg_wdata (floor_count)
//
// A rejected request answers in the cycle after start and leaves busy low.
// A valid request runs passes of count, evaluate and (on a move) move steps;
// a pass that stops at the car's floor with no calls left adds a rest step,
// and the 48-event counter bounds how long busy stays high.
// Results come one per strobe cycle and cannot be stalled.
// Synchronous active-low reset: car at floor 1, no calls, heading idle, 16 floors.
`timescale 1ns / 1ps
`default_nettype none

module elevator_call_scheduler (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [ecs_pkg::FLOOR_W-1:0] i_request_floor,
    input  wire logic                        i_cfg_we,
    input  wire logic [ecs_pkg::FLOOR_W-1:0] i_cfg_wdata,
    output logic                             o_strobe,
    output logic [1:0]                       o_event_kind,
    output logic [ecs_pkg::FLOOR_W-1:0]      o_car_floor,
    output logic signed [1:0]                o_travel_direction,
    output logic                             o_last_event
);
    import ecs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ecs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ecs_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_request_floor    (i_request_floor),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_strobe           (o_strobe),
        .o_event_kind       (o_event_kind),
        .o_car_floor        (o_car_floor),
        .o_travel_direction (o_travel_direction),
        .o_last_event       (o_last_event)
    );

endmodule

`default_nettype wire
